@@ src/c3s_pkg.sv @@
// ---------------------------------------------------------------------------
// c3s_pkg - shared types and constants of the 3x3 Cramer solver
// Widths of the determinant datapath, the divider and the queued item.
// ---------------------------------------------------------------------------
`default_nettype none

package c3s_pkg;

    // input and output formats
    localparam int IN_W   = 16;
    localparam int FRAC   = 16;
    localparam int OUT_W  = 32;

    // determinant datapath
    localparam int PRD_W  = 2 * IN_W;
    localparam int MIN_W  = PRD_W + 1;
    localparam int TRM_W  = IN_W + MIN_W;
    localparam int DET_W  = TRM_W + 2;

    // divider
    localparam int DEN_W  = DET_W;
    localparam int NUM_W  = DET_W + FRAC;
    localparam int Q_W    = OUT_W + 1;
    localparam int CMP_W  = DEN_W + Q_W;
    localparam int LANE_D = Q_W + 2;

    // queue between front and back
    localparam int FIFO_D = 4;
    localparam int PTR_W  = $clog2(FIFO_D);
    localparam int CNT_W  = $clog2(FIFO_D + 1);

    // saturation limits on the rounded magnitude
    localparam logic [Q_W:0] SAT_POS = (Q_W + 1)'({1'b0, {(OUT_W - 1){1'b1}}});
    localparam logic [Q_W:0] SAT_NEG = (Q_W + 1)'({1'b1, {(OUT_W - 1){1'b0}}});

    // one classified system, ready for division
    typedef struct packed {
        logic [2:0][NUM_W-1:0] num;
        logic [2:0]            neg;
        logic [DEN_W-1:0]      den;
        logic                  singular;
    } fe_item_t;

endpackage

`default_nettype wire

@@ src/c3s_front.sv @@
// ---------------------------------------------------------------------------
// c3s_front - determinant pipeline and classification
// Forms the main determinant and the three column-replaced determinants in
// five stages, then splits them into magnitudes, signs and a singular flag.
// ---------------------------------------------------------------------------
`default_nettype none

module c3s_front (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [12*c3s_pkg::IN_W-1:0] in_data,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output c3s_pkg::fe_item_t             out_item
);
    import c3s_pkg::*;

    logic                     en;
    logic signed [IN_W-1:0]   mat [4][3][3];
    logic [4:0]               v_reg;

    logic signed [PRD_W-1:0]  p_reg   [4][6];
    logic signed [IN_W-1:0]   r0a_reg [4][3];
    logic signed [MIN_W-1:0]  c_reg   [4][3];
    logic signed [IN_W-1:0]   r0b_reg [4][3];
    logic signed [TRM_W-1:0]  t_reg   [4][3];
    logic signed [DET_W-1:0]  det_reg [4];
    fe_item_t                 item_reg;
    logic [DEN_W-1:0]         mag     [4];

    // advance the whole pipe unless the last stage is blocked
    assign en        = !v_reg[4] || out_ready;
    assign in_ready  = en;
    assign out_valid = v_reg[4];
    assign out_item  = item_reg;

    // build the main matrix and the three with one column replaced
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    if (k != 0 && j == k - 1)
                        mat[k][i][j] = in_data[(9 + i) * IN_W +: IN_W];
                    else
                        mat[k][i][j] = in_data[(i * 3 + j) * IN_W +: IN_W];
                end
            end
        end
    end

    // magnitudes of the determinants
    always_comb
    begin
        for (int k = 0; k < 4; k++)
            mag[k] = det_reg[k][DET_W-1] ? DEN_W'(-det_reg[k]) : DEN_W'(det_reg[k]);
    end

    // track valid items through the stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[3:0], in_valid};
    end

    // datapath stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 4; k++)
            begin
                // products of rows one and two
                p_reg[k][0] <= mat[k][1][1] * mat[k][2][2];
                p_reg[k][1] <= mat[k][1][2] * mat[k][2][1];
                p_reg[k][2] <= mat[k][1][0] * mat[k][2][2];
                p_reg[k][3] <= mat[k][1][2] * mat[k][2][0];
                p_reg[k][4] <= mat[k][1][0] * mat[k][2][1];
                p_reg[k][5] <= mat[k][1][1] * mat[k][2][0];
                for (int j = 0; j < 3; j++)
                    r0a_reg[k][j] <= mat[k][0][j];

                // 2x2 minors
                c_reg[k][0] <= MIN_W'(p_reg[k][0]) - MIN_W'(p_reg[k][1]);
                c_reg[k][1] <= MIN_W'(p_reg[k][2]) - MIN_W'(p_reg[k][3]);
                c_reg[k][2] <= MIN_W'(p_reg[k][4]) - MIN_W'(p_reg[k][5]);
                for (int j = 0; j < 3; j++)
                    r0b_reg[k][j] <= r0a_reg[k][j];

                // cofactor terms
                for (int j = 0; j < 3; j++)
                    t_reg[k][j] <= r0b_reg[k][j] * c_reg[k][j];

                // determinant sum
                det_reg[k] <= DET_W'(t_reg[k][0]) - DET_W'(t_reg[k][1])
                              + DET_W'(t_reg[k][2]);
            end

            // classify: sign, magnitude, singular
            item_reg.den      <= mag[0];
            item_reg.singular <= (det_reg[0] == '0);
            for (int k = 1; k < 4; k++)
            begin
                item_reg.num[k-1] <= {mag[k], {FRAC{1'b0}}};
                item_reg.neg[k-1] <= det_reg[k][DET_W-1] ^ det_reg[0][DET_W-1];
            end
        end
    end

endmodule

`default_nettype wire

@@ src/c3s_fifo.sv @@
// ---------------------------------------------------------------------------
// c3s_fifo - short queue between front and back
// Register-based first-in first-out queue of classified items.
// ---------------------------------------------------------------------------
`default_nettype none

module c3s_fifo (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire c3s_pkg::fe_item_t din,
    output logic                   full,
    input  wire logic              pop,
    output c3s_pkg::fe_item_t      dout,
    output logic                   empty
);
    import c3s_pkg::*;

    fe_item_t          mem_reg [FIFO_D];
    logic [PTR_W-1:0]  wr_reg;
    logic [PTR_W-1:0]  rd_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              do_push;
    logic              do_pop;

    assign full    = (cnt_reg == CNT_W'(FIFO_D));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_reg];

    // advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
                wr_reg <= wr_reg + 1'b1;
            if (do_pop)
                rd_reg <= rd_reg + 1'b1;
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // store the item
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_reg] <= din;
    end

endmodule

`default_nettype wire

@@ src/c3s_div_lane.sv @@
// ---------------------------------------------------------------------------
// c3s_div_lane - pipelined divider with rounding and saturation
// One quotient bit per stage, then round half away from zero and clamp the
// signed result to the output range.
// ---------------------------------------------------------------------------
`default_nettype none

module c3s_div_lane (
    input  wire logic                        clk,
    input  wire logic                        en,
    input  wire logic [c3s_pkg::NUM_W-1:0]   num,
    input  wire logic [c3s_pkg::DEN_W-1:0]   den,
    input  wire logic                        neg,
    output logic      [c3s_pkg::OUT_W-1:0]   sol
);
    import c3s_pkg::*;

    logic [NUM_W-1:0]  r_reg [Q_W+1];
    logic [Q_W-1:0]    q_reg [Q_W+1];
    logic [DEN_W-1:0]  d_reg [Q_W+1];
    logic              n_reg [Q_W+1];
    logic              o_reg [Q_W+1];
    logic [NUM_W-1:0]  r_nx  [Q_W+1];
    logic              ge    [Q_W+1];
    logic [CMP_W-1:0]  sh    [Q_W+1];
    logic [Q_W:0]      qr_reg;
    logic              rn_reg;
    logic              ro_reg;
    logic              rnd;

    // trial subtraction of each step
    always_comb
    begin
        r_nx[0] = '0;
        ge[0]   = 1'b0;
        sh[0]   = '0;
        for (int s = 1; s <= Q_W; s++)
        begin
            sh[s]   = CMP_W'(d_reg[s-1]) << (Q_W - s);
            ge[s]   = CMP_W'(r_reg[s-1]) >= sh[s];
            r_nx[s] = ge[s] ? NUM_W'(CMP_W'(r_reg[s-1]) - sh[s]) : r_reg[s-1];
        end
    end

    // round when twice the remainder reaches the divisor
    assign rnd = {r_reg[Q_W], 1'b0} >= (NUM_W + 1)'(d_reg[Q_W]);

    // clamp and apply the sign
    always_comb
    begin
        if (!rn_reg)
            sol = (ro_reg || qr_reg > SAT_POS) ? OUT_W'(SAT_POS) : OUT_W'(qr_reg);
        else
            sol = (ro_reg || qr_reg > SAT_NEG) ? OUT_W'(SAT_NEG) : OUT_W'(-qr_reg);
    end

    // divider stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg[0] <= num;
            q_reg[0] <= '0;
            d_reg[0] <= den;
            n_reg[0] <= neg;
            o_reg[0] <= CMP_W'(num) >= (CMP_W'(den) << Q_W);
            for (int s = 1; s <= Q_W; s++)
            begin
                r_reg[s] <= r_nx[s];
                q_reg[s] <= {q_reg[s-1][Q_W-2:0], ge[s]};
                d_reg[s] <= d_reg[s-1];
                n_reg[s] <= n_reg[s-1];
                o_reg[s] <= o_reg[s-1];
            end
            qr_reg <= (Q_W + 1)'(q_reg[Q_W]) + (Q_W + 1)'(rnd);
            rn_reg <= n_reg[Q_W];
            ro_reg <= o_reg[Q_W];
        end
    end

endmodule

`default_nettype wire

@@ src/c3s_back.sv @@
// ---------------------------------------------------------------------------
// c3s_back - division back end and output register
// Three divider lanes in lock step, a valid and singular pipe beside them,
// and the output register that holds a result until it is taken.
// ---------------------------------------------------------------------------
`default_nettype none

module c3s_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire c3s_pkg::fe_item_t             in_item,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [3*c3s_pkg::OUT_W-1:0]        out_data,
    output logic                               out_singular
);
    import c3s_pkg::*;

    logic                     en;
    logic [LANE_D-1:0]        v_reg;
    logic [LANE_D-1:0]        s_reg;
    logic [OUT_W-1:0]         sol [3];
    logic                     ov_reg;
    logic [3*OUT_W-1:0]       od_reg;
    logic                     os_reg;

    assign en           = !ov_reg || out_ready;
    assign in_ready     = en;
    assign out_valid    = ov_reg;
    assign out_data     = od_reg;
    assign out_singular = os_reg;

    // divider lanes
    for (genvar g = 0; g < 3; g++)
    begin : g_lane
        c3s_div_lane u_lane (
            .clk (clk),
            .en  (en),
            .num (in_item.num[g]),
            .den (in_item.den),
            .neg (in_item.neg[g]),
            .sol (sol[g])
        );
    end

    // valid and output flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg  <= '0;
            ov_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg  <= {v_reg[LANE_D-2:0], in_valid};
            ov_reg <= v_reg[LANE_D-1];
        end
    end

    // singular pipe and result register; drop the quotients when singular
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg  <= {s_reg[LANE_D-2:0], in_item.singular};
            os_reg <= s_reg[LANE_D-1];
            od_reg <= s_reg[LANE_D-1] ? '0 : {sol[2], sol[1], sol[0]};
        end
    end

endmodule

`default_nettype wire

@@ src/cramer_3x3_solver_core.sv @@
// ---------------------------------------------------------------------------
// cramer_3x3_solver_core - 3x3 linear system solver by Cramer's rule
//
// Slave channel: one item per system, twelve signed Q8.8 words (matrix
// row-major, then the right-hand vector). Master channel: three signed
// Q16.16 solution words, rounded half away from zero and saturated, with a
// singular flag in tuser; on a singular matrix the words are zero.
// Throughput: one item per cycle unless the receiver stalls. A result passes
// through the five-stage determinant pipe, the queue and the 33-step divider
// with its rounding stage, then the output register.
// Reset clears all valid state; the queue starts empty and nothing is output.
// When the receiver stalls the back end holds, the queue of four items fills,
// then the front end holds and s_axis_tready falls.
// ---------------------------------------------------------------------------
`default_nettype none

module cramer_3x3_solver_core (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // a00 a01 a02 a10 a11 a12 a20 a21 a22 rhs0 rhs1 rhs2, 16 bits each
    input  wire logic [12*c3s_pkg::IN_W-1:0]      s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // sol0 sol1 sol2, 32 bits each
    output logic [3*c3s_pkg::OUT_W-1:0]           m_axis_tdata,
    // singular
    output logic                                  m_axis_tuser
);
    import c3s_pkg::*;

    fe_item_t  fe_item;
    fe_item_t  q_item;
    logic      fe_valid;
    logic      q_full;
    logic      q_empty;
    logic      be_ready;

    // determinant front end
    c3s_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (s_axis_tdata),
        .out_valid (fe_valid),
        .out_ready (!q_full),
        .out_item  (fe_item)
    );

    // decoupling queue
    c3s_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fe_valid),
        .din   (fe_item),
        .full  (q_full),
        .pop   (be_ready),
        .dout  (q_item),
        .empty (q_empty)
    );

    // division back end
    c3s_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (!q_empty),
        .in_ready     (be_ready),
        .in_item      (q_item),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_data     (m_axis_tdata),
        .out_singular (m_axis_tuser)
    );

endmodule

`default_nettype wire

@@ tb/cramer_3x3_solver_core_tb.sv @@
// ---------------------------------------------------------------------------
// cramer_3x3_solver_core_tb - self-checking bench for the 3x3 Cramer solver
// Drives systems on the slave stream with random gaps, predicts each solution
// with an exact wide-integer model and checks the master stream in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module cramer_3x3_solver_core_tb;

    localparam int IW = c3s_pkg::IN_W;
    localparam int OW = c3s_pkg::OUT_W;
    localparam int FB = c3s_pkg::FRAC;
    localparam int N_DIRECTED = 20;
    localparam int N_RANDOM = 1250;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [OW-1:0] sol2;
        logic [OW-1:0] sol1;
        logic [OW-1:0] sol0;
        logic          singular;
    } solution_t;

    // Exact Cramer solver for one system, with rounding and saturation
    class solution_board;
        solution_t pending[$];
        int        n_bad;

        function automatic logic signed [127:0] det3(logic signed [127:0] m[9]);
            return m[0] * (m[4] * m[8] - m[5] * m[7])
                 - m[1] * (m[3] * m[8] - m[5] * m[6])
                 + m[2] * (m[3] * m[7] - m[4] * m[6]);
        endfunction

        function automatic logic [OW-1:0] divide(logic signed [127:0] num,
                                                 logic signed [127:0] den);
            logic        neg;
            logic [127:0] n, d, q, r;
            neg = num[127] ^ den[127];
            n = num[127] ? -num : num;
            d = den[127] ? -den : den;
            n = n << FB;
            q = n / d;
            r = n % d;
            if ((r << 1) >= d)
                q = q + 1;
            if (!neg)
                return (q > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[OW-1:0];
            return (q > 128'h8000_0000) ? 32'h8000_0000 : (-q[OW-1:0]);
        endfunction

        function void note_system(logic [12*IW-1:0] data);
            logic signed [127:0] m[9], t[9], rv[3], d;
            solution_t s;
            for (int i = 0; i < 9; i++)
                m[i] = 128'(signed'(data[i*IW +: IW]));
            for (int i = 0; i < 3; i++)
                rv[i] = 128'(signed'(data[(9+i)*IW +: IW]));
            d = det3(m);
            s = '0;
            if (d == 0)
                s.singular = 1'b1;
            else
            begin
                for (int k = 0; k < 3; k++)
                begin
                    t = m;
                    for (int i = 0; i < 3; i++)
                        t[i*3+k] = rv[i];
                    if (k == 0) s.sol0 = divide(det3(t), d);
                    if (k == 1) s.sol1 = divide(det3(t), d);
                    if (k == 2) s.sol2 = divide(det3(t), d);
                end
            end
            pending.push_back(s);
        endfunction

        function void check_solution(logic [3*OW-1:0] data, logic sing);
            solution_t exp_s, got;
            got = {data[95:64], data[63:32], data[31:0], sing};
            if (pending.size() == 0)
            begin
                n_bad++;
                if (n_bad <= 10)
                    $display("unexpected item: %h sing %b", data, sing);
                return;
            end
            exp_s = pending.pop_front();
            if (got !== exp_s)
            begin
                n_bad++;
                if (n_bad <= 10)
                    $display("mismatch: exp %h %h %h s%b got %h %h %h s%b",
                             exp_s.sol0, exp_s.sol1, exp_s.sol2, exp_s.singular,
                             got.sol0, got.sol1, got.sol2, got.singular);
            end
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [12*IW-1:0] s_axis_tdata;
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [3*OW-1:0]  m_axis_tdata;
    logic             m_axis_tuser;

    solution_board board;
    bit            calm;
    bit            sent_all;
    int            cycles;

    cramer_3x3_solver_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Pick one entry: extremes, small values or anything
    function automatic logic [IW-1:0] pick_word();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'(int'($urandom_range(0, 8)) - 4);
            3: return 16'(int'($urandom_range(0, 1024)) - 512);
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic [12*IW-1:0] random_system();
        logic [12*IW-1:0] v;
        for (int i = 0; i < 12; i++)
            v[i*IW +: IW] = pick_word();
        // make some matrices singular: copy a row or zero a column
        case ($urandom_range(0, 7))
            0: v[3*IW +: 3*IW] = v[0 +: 3*IW];
            1: for (int i = 0; i < 3; i++) v[(i*3+1)*IW +: IW] = '0;
            default: ;
        endcase
        return v;
    endfunction

    // Offer one system and hold it until accepted
    task automatic send_system(logic [12*IW-1:0] v);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        do @(posedge clk); while (!s_axis_tready);
        board.note_system(v);
    endtask

    function automatic logic [12*IW-1:0] diag_system(logic [IW-1:0] a, logic [IW-1:0] r);
        logic [12*IW-1:0] v;
        v = '0;
        v[0*IW +: IW] = a; v[4*IW +: IW] = a; v[8*IW +: IW] = a;
        v[9*IW +: IW] = r; v[10*IW +: IW] = r; v[11*IW +: IW] = r;
        return v;
    endfunction

    // Source: directed systems then random ones
    initial
    begin
        logic [12*IW-1:0] v;
        board = new();
        calm = 1'b0;
        sent_all = 1'b0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_system(diag_system(16'h0100, 16'h0100));
        send_system(diag_system(16'h0100, 16'h8000));
        send_system(diag_system(16'h0001, 16'h7FFF));
        send_system(diag_system(16'h0001, 16'h8000));
        send_system(diag_system(16'hFFFF, 16'h7FFF));
        send_system(diag_system(16'h8000, 16'h7FFF));
        send_system(diag_system(16'h7FFF, 16'h8000));
        send_system(diag_system(16'h0003, 16'h0001));
        send_system(diag_system(16'h0003, 16'hFFFF));
        send_system(diag_system(16'h0003, 16'h0002));
        send_system(diag_system(16'h0000, 16'h1234));
        send_system('0);
        send_system({12{16'h7FFF}});
        send_system({12{16'h8000}});
        send_system({12{16'hFFFF}});
        v = '0;
        for (int i = 0; i < 12; i++)
            v[i*IW +: IW] = (i % 2) ? 16'h8000 : 16'h7FFF;
        send_system(v);
        for (int i = 0; i < N_DIRECTED - 16; i++)
            send_system(random_system());
        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i == N_RANDOM - 150)
                calm = 1'b1;
            send_system(random_system());
        end
        s_axis_tvalid <= 1'b0;
        sent_all = 1'b1;
    end

    // Sink: random stalls, one long hold-off, none at the end
    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        repeat (300) @(posedge clk);
        m_axis_tready <= 1'b0;
        repeat (200) @(posedge clk);
        forever
        begin
            if (!calm && $urandom_range(0, 3) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    // Check every accepted result item
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            board.check_solution(m_axis_tdata, m_axis_tuser);
    end

    // Finish once drained, or on timeout
    initial
    begin
        cycles = 0;
        while (!(sent_all && board.pending.size() == 0) && cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("** cramer_3x3_solver_core: FAILED **");
        end
        else
        begin
            repeat (100) @(posedge clk);
            if (board.n_bad == 0)
                $display("** cramer_3x3_solver_core: PASSED **");
            else
                $display("** cramer_3x3_solver_core: FAILED **");
        end
        $finish;
    end

endmodule

@@ sim.f @@
src/c3s_pkg.sv
src/c3s_front.sv
src/c3s_fifo.sv
src/c3s_div_lane.sv
src/c3s_back.sv
src/cramer_3x3_solver_core.sv
tb/cramer_3x3_solver_core_tb.sv
